// File: design/sha1h_pkg.sv
// Shared types, constants and helper functions of the SHA-1 stream hasher.
package sha1h_pkg;

	// Geometry of the hash.
	localparam int BLOCK_WORDS  = 16;
	localparam int ROUNDS       = 80;
	localparam int DIGEST_WORDS = 5;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Initial chaining values.
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

	// Round constants.
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	// Source of the byte shifted into the block buffer.
	localparam logic [1:0] BSEL_MSG  = 2'd0;
	localparam logic [1:0] BSEL_PAD  = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_byte;
		logic [1:0] byte_sel;
		logic       count_bits;
		logic       init_work;
		logic       do_round;
		logic [6:0] rnd;
		logic       add_chain;
		logic       reset_msg;
		logic [2:0] out_idx;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] pos;
	} status_t;

	function automatic logic [31:0] rotl1(input logic [31:0] v);
		return {v[30:0], v[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] v);
		return {v[26:0], v[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] v);
		return {v[1:0], v[31:2]};
	endfunction

	// Round constant for round t.
	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = K0;
		end else if (t < 7'd40) begin
			k = K1;
		end else if (t < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	// Boolean function for round t.
	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40 || t >= 7'd60) begin
			f = b ^ c ^ d;
		end else begin
			f = (b & c) | (b & d) | (c & d);
		end
		return f;
	endfunction

endpackage

// File: design/sha1h_if.sv
// Handshake channel interfaces for message bytes in and digest words out.
interface sha1h_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] message_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source(output valid, output message_byte, output has_byte,
		output end_of_message, input ready);
	modport sink(input valid, input message_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface sha1h_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink(input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// File: design/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher: controller, datapath and channel wiring.
//
// Usage: message bytes enter on the feed channel, one item per byte, most
// significant byte first within each 32-bit word. An item with end_of_message
// set closes the message after appending its own byte, if it has one; an
// item with has_byte low and end_of_message set closes the message as it
// stands, and an empty message gives the digest of no bytes at all.
// Intake: a byte that does not complete a 64-byte block leaves the feed ready
// for the next byte. The byte that completes a block is followed by 80 rounds
// of the single round unit, one per cycle, and the chaining add, and no new
// byte is taken until these are done.
// Closing a message feeds the pad byte, the zero fill and the length one byte
// a cycle through the block buffer, pausing while each full block is
// compressed; one or two blocks are compressed before the first digest word.
// The five digest words h0 to h4 then leave on the digest channel, the last
// one marked; a stalled receiver simply holds the current word, and no new
// item is taken until all five words are gone.
// Reset puts back the initial chaining value, clears the bit count and
// leaves the block ready for a new message; it does the same by itself
// after the fifth digest word is taken.
module sha1_stream_hasher (
	input logic        clk,
	input logic        arst_n,
	sha1h_in_if.sink   feed,
	sha1h_out_if.source digest
);

	sha1h_pkg::cmd_t    cmd;
	sha1h_pkg::status_t status;

	sha1h_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (feed.valid),
		.in_has_byte (feed.has_byte),
		.in_end      (feed.end_of_message),
		.in_ready    (feed.ready),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.status      (status),
		.cmd         (cmd)
	);

	sha1h_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_byte (feed.message_byte),
		.status       (status),
		.digest_word  (digest.digest_word)
	);

	// Word index and last mark follow the controller's output counter.
	assign digest.word_index = cmd.out_idx;
	assign digest.last_word  = (cmd.out_idx == 3'(sha1h_pkg::DIGEST_WORDS - 1));

endmodule

// File: design/sha1h_datapath.sv
// Datapath of the SHA-1 hasher: block buffer, schedule, round unit, chain and bit count.
module sha1h_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1h_pkg::cmd_t   cmd,
	input  logic [7:0]        message_byte,
	output sha1h_pkg::status_t status,
	output logic [31:0]       digest_word
);

	logic [31:0] w_q [sha1h_pkg::BLOCK_WORDS];
	logic [31:0] chain_q [sha1h_pkg::DIGEST_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] bit_count_q;
	logic [5:0]  pos_q;

	logic [7:0]  byte_in;
	logic [63:0] len_shifted;
	logic [31:0] wt;
	logic [31:0] sum;

	// Length byte for positions 56 to 63, most significant byte first.
	assign len_shifted = bit_count_q >> {~pos_q[2:0], 3'b000};

	// Byte that enters the buffer.
	always_comb begin
		case (cmd.byte_sel)
			sha1h_pkg::BSEL_MSG:  byte_in = message_byte;
			sha1h_pkg::BSEL_PAD:  byte_in = sha1h_pkg::PAD_BYTE;
			sha1h_pkg::BSEL_ZERO: byte_in = 8'h00;
			sha1h_pkg::BSEL_LEN:  byte_in = len_shifted[7:0];
			default:              byte_in = 8'h00;
		endcase
	end

	// Schedule word of the current round and the round sum.
	always_comb begin
		if (cmd.rnd < 7'd16) begin
			wt = w_q[0];
		end else begin
			wt = sha1h_pkg::rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
		end
		sum = sha1h_pkg::rotl5(a_q) + sha1h_pkg::round_f(cmd.rnd, b_q, c_q, d_q) + e_q
			+ sha1h_pkg::round_k(cmd.rnd) + wt;
	end

	// Block buffer: bytes shift in at the bottom, rounds roll the schedule a word at a time.
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			for (int i = 0; i < sha1h_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[sha1h_pkg::BLOCK_WORDS - 1] <= {w_q[sha1h_pkg::BLOCK_WORDS - 1][23:0], byte_in};
		end else if (cmd.do_round) begin
			for (int i = 0; i < sha1h_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha1h_pkg::BLOCK_WORDS - 1] <= wt;
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.do_round) begin
			a_q <= sum;
			b_q <= a_q;
			c_q <= sha1h_pkg::rotl30(b_q);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Chaining value, bit count and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0]  <= sha1h_pkg::H0_INIT;
			chain_q[1]  <= sha1h_pkg::H1_INIT;
			chain_q[2]  <= sha1h_pkg::H2_INIT;
			chain_q[3]  <= sha1h_pkg::H3_INIT;
			chain_q[4]  <= sha1h_pkg::H4_INIT;
			bit_count_q <= 64'd0;
			pos_q       <= 6'd0;
		end else if (cmd.reset_msg) begin
			chain_q[0]  <= sha1h_pkg::H0_INIT;
			chain_q[1]  <= sha1h_pkg::H1_INIT;
			chain_q[2]  <= sha1h_pkg::H2_INIT;
			chain_q[3]  <= sha1h_pkg::H3_INIT;
			chain_q[4]  <= sha1h_pkg::H4_INIT;
			bit_count_q <= 64'd0;
			pos_q       <= 6'd0;
		end else begin
			if (cmd.add_chain) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.count_bits) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.load_byte) begin
				pos_q <= pos_q + 6'd1;
			end
		end
	end

	// Digest word selected for the output channel.
	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			3'd4:    digest_word = chain_q[4];
			default: digest_word = chain_q[0];
		endcase
	end

	assign status.pos = pos_q;

endmodule

// File: design/sha1h_ctrl.sv
// Controller of the SHA-1 hasher: byte intake, padding, round sequencing and digest output.
module sha1h_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_has_byte,
	input  logic               in_end,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sha1h_pkg::status_t status,
	output sha1h_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] idx_q, idx_d;
	logic       pad_q, pad_d;     // message closed, padding under way
	logic       first_q, first_d; // pad byte still to be written
	logic       len_q, len_d;     // length may go into this block
	logic       last_q, last_d;   // length written, digest follows compression

	logic in_acc, out_acc, blk_full, len_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign blk_full  = (status.pos == 6'd63);
	assign len_byte  = !first_q && len_q && (status.pos >= 6'd56);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		rnd_d   = rnd_q;
		idx_d   = idx_q;
		pad_d   = pad_q;
		first_d = first_q;
		len_d   = len_q;
		last_d  = last_q;

		cmd            = '0;
		cmd.byte_sel   = sha1h_pkg::BSEL_MSG;
		cmd.rnd        = rnd_q;
		cmd.out_idx    = idx_q;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_has_byte) begin
						cmd.load_byte  = 1'b1;
						cmd.count_bits = 1'b1;
					end
					if (in_end) begin
						pad_d   = 1'b1;
						first_d = 1'b1;
						last_d  = 1'b0;
					end
					if (in_has_byte && blk_full) begin
						cmd.init_work = 1'b1;
						state_d       = S_ROUND;
					end else if (in_end) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.load_byte = 1'b1;
				if (first_q) begin
					cmd.byte_sel = sha1h_pkg::BSEL_PAD;
				end else if (len_byte) begin
					cmd.byte_sel = sha1h_pkg::BSEL_LEN;
				end else begin
					cmd.byte_sel = sha1h_pkg::BSEL_ZERO;
				end
				first_d = 1'b0;
				// A pad byte late in the block pushes the length into a fresh block.
				if (blk_full) begin
					len_d = 1'b1;
				end else if (first_q) begin
					len_d = (status.pos < 6'd56);
				end
				if (blk_full) begin
					last_d        = len_byte;
					cmd.init_work = 1'b1;
					state_d       = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.do_round = 1'b1;
				if (rnd_q == 7'(sha1h_pkg::ROUNDS - 1)) begin
					rnd_d   = 7'd0;
					state_d = S_ADD;
				end else begin
					rnd_d = rnd_q + 7'd1;
				end
			end
			S_ADD: begin
				cmd.add_chain = 1'b1;
				if (last_q) begin
					idx_d   = 3'd0;
					state_d = S_OUT;
				end else if (pad_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_acc) begin
					if (idx_q == 3'(sha1h_pkg::DIGEST_WORDS - 1)) begin
						cmd.reset_msg = 1'b1;
						idx_d         = 3'd0;
						pad_d         = 1'b0;
						last_d        = 1'b0;
						state_d       = S_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= 7'd0;
			idx_q   <= 3'd0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
			pad_q   <= pad_d;
			first_q <= first_d;
			len_q   <= len_d;
			last_q  <= last_d;
		end
	end

	// The round counter only runs during compression.
	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rnd_q != 7'd0) |-> (state_q == S_ROUND))
		else $error("round counter nonzero outside compression");

	// Input and output channels are never open at the same time.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest is presented");

	// The final compression leads straight to the digest output.
	a_add_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && last_q) |=> (state_q == S_OUT && idx_q == 3'd0))
		else $error("digest output did not follow the final compression");

	// The digest word index stays within the five words.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < 3'(sha1h_pkg::DIGEST_WORDS)))
		else $error("digest word index out of range");

endmodule
